/* hw/rtl/affine_matrix_inverse_core_macros.svh */
// Assertion macros shared by the affine matrix inverse core.
// Both expect clk and rst in scope at the place of use.
`ifndef AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AMIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AMIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/amic_pkg.sv */
package amic_pkg;

  // Coefficient format and default fraction size.
  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Widths of the exact intermediate values.
  localparam int PROD_W = 2 * COEF_WIDTH;          // element product
  localparam int COF_W  = PROD_W + 1;              // cofactor
  localparam int LO_W   = COEF_WIDTH;              // low slice of a cofactor
  localparam int HI_W   = COF_W - LO_W;            // high slice of a cofactor
  localparam int PART_W = HI_W + COEF_WIDTH;       // partial product
  localparam int TERM_W = COF_W + COEF_WIDTH;      // full cofactor product
  localparam int DET_W  = TERM_W + 2;              // sum of three terms

  // Division lane depth: two prep stages, one overflow stage,
  // one stage per quotient bit and the output register.
  localparam int DIV_LAT = COEF_WIDTH + 4;

  // Row numbers of the inverse.
  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  // Cofactor c = e[A]*e[B] - e[C]*e[D], elements indexed 4*row + col.
  localparam logic [3:0] COF_A [9] = '{4'd5, 4'd2, 4'd1, 4'd6, 4'd0, 4'd2, 4'd4, 4'd1, 4'd0};
  localparam logic [3:0] COF_B [9] = '{4'd10, 4'd9, 4'd6, 4'd8, 4'd10, 4'd4, 4'd9, 4'd8, 4'd5};
  localparam logic [3:0] COF_C [9] = '{4'd6, 4'd1, 4'd2, 4'd4, 4'd2, 4'd0, 4'd5, 4'd0, 4'd1};
  localparam logic [3:0] COF_D [9] = '{4'd9, 4'd10, 4'd5, 4'd10, 4'd8, 4'd6, 4'd8, 4'd9, 4'd4};

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    coef_t row1_col1;
    coef_t row1_col2;
    coef_t row1_col3;
    coef_t row1_shift;
    coef_t row2_col1;
    coef_t row2_col2;
    coef_t row2_col3;
    coef_t row2_shift;
    coef_t row3_col1;
    coef_t row3_col2;
    coef_t row3_col3;
    coef_t row3_shift;
  } matrix_t;

  typedef struct packed {
    coef_t            out_col1;
    coef_t            out_col2;
    coef_t            out_col3;
    coef_t            out_shift;
    logic [ROW_W-1:0] row_number;
    logic             last_row;
    logic             singular;
  } inv_row_t;

  // Row tag that travels beside the division lanes.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row_number;
    logic             last_row;
    logic             singular;
  } row_meta_t;

endpackage

/* hw/rtl/amic_div.sv */
// Pipelined restoring divider: rounds num/den to nearest, ties away from
// zero, and saturates to a signed coefficient. One quotient bit per stage.
module amic_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output amic_pkg::coef_t         quot
);

  localparam int QB = amic_pkg::COEF_WIDTH;
  localparam int DW = NUM_W + QB + 3;

  logic [NUM_W-1:0] n_mag;
  logic [DEN_W-1:0] d_mag;
  logic [NUM_W-1:0] p1_n;
  logic [DEN_W-1:0] p1_d;
  logic             p1_neg;

  logic [DW-1:0] rem [QB+2];
  logic [DW-1:0] dvs [QB+2];
  logic [QB-1:0] qb  [QB+2];
  logic          ovf [QB+2];
  logic          ngt [QB+2];

  logic          sat;
  logic [QB-1:0] mag;

  // Magnitudes and result sign.
  assign n_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign d_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n   <= n_mag;
      p1_d   <= d_mag;
      p1_neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // Rounding: floor((2n + d) / 2d).
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (DW'(p1_n) << 1) + DW'(p1_d);
      dvs[0] <= DW'(p1_d) << 1;
      qb[0]  <= '0;
      ovf[0] <= 1'b0;
      ngt[0] <= p1_neg;
    end
  end

  // The first stage only flags a quotient too large for the output,
  // each later stage settles one quotient bit.
  for (genvar j = 0; j <= QB; j++) begin : g_stage
    logic [DW-1:0] shifted;
    logic          ge;

    assign shifted = dvs[j] << (QB - j);
    assign ge      = rem[j] >= shifted;

    if (j == 0) begin : g_ovf
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= rem[j];
          dvs[j+1] <= dvs[j];
          qb[j+1]  <= qb[j];
          ovf[j+1] <= ge;
          ngt[j+1] <= ngt[j];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? rem[j] - shifted : rem[j];
          dvs[j+1] <= dvs[j];
          qb[j+1]  <= qb[j] | (QB'(ge) << (QB - j));
          ovf[j+1] <= ovf[j];
          ngt[j+1] <= ngt[j];
        end
      end
    end
  end

  // Saturate and apply the sign.
  assign sat = ovf[QB+1] || qb[QB+1][QB-1];

  always_comb begin
    if (sat) begin
      mag = ngt[QB+1] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    end else begin
      mag = qb[QB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= ngt[QB+1] ? amic_pkg::coef_t'(-mag) : amic_pkg::coef_t'(mag);
    end
  end

endmodule

/* hw/rtl/affine_matrix_inverse_core.sv */
// Channel  Direction  Payload                 Handshake
// matrix   in         amic_pkg::matrix_t      matrix_valid / matrix_ready
// row      out        amic_pkg::inv_row_t     row_valid / row_ready
//
// A matrix is taken at best once per three rows: it leaves as three rows, one row per cycle
// unless a row waits on row_ready, through the four division lanes that share the single row channel.
// Row 0 passes the five matrix stages, the row sequencer and the lanes; rows 1 and 2 follow.
// Reset (rst, synchronous) clears the valid bits, the row counter and the row tags; no clearing pass.
// While a row waits and row_ready is low the division lanes and the row sequencer hold; the
// five matrix stages keep filling bubbles, then matrix_ready drops.
`include "affine_matrix_inverse_core_macros.svh"

module affine_matrix_inverse_core #(
  parameter int FRAC_BITS = amic_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               matrix_valid,
  output logic               matrix_ready,
  input  amic_pkg::matrix_t  matrix,
  output logic               row_valid,
  input  logic               row_ready,
  output amic_pkg::inv_row_t row
);

  localparam int CW    = amic_pkg::COEF_WIDTH;
  localparam int PW    = amic_pkg::PROD_W;
  localparam int FW    = amic_pkg::COF_W;
  localparam int LW    = amic_pkg::LO_W;
  localparam int HW    = amic_pkg::HI_W;
  localparam int AW    = amic_pkg::PART_W;
  localparam int TW    = amic_pkg::TERM_W;
  localparam int DW    = amic_pkg::DET_W;
  localparam int NUM_W = DW + 2 * FRAC_BITS;
  localparam int LAT   = amic_pkg::DIV_LAT;

  // Stage enables.
  logic adv;
  logic ser_take;
  logic en1, en2, en3, en4, en5;

  // Matrix stages.
  amic_pkg::coef_t        e [12];
  logic signed [PW-1:0]   prod [18];
  logic                   f1_valid;
  logic signed [PW-1:0]   f1_prod [18];
  amic_pkg::coef_t        f1_e [3];
  amic_pkg::coef_t        f1_t [3];

  logic                   f2_valid;
  logic signed [FW-1:0]   f2_cof [9];
  amic_pkg::coef_t        f2_e [3];
  amic_pkg::coef_t        f2_t [3];

  logic signed [AW-1:0]   dlo [3];
  logic signed [AW-1:0]   dhi [3];
  logic signed [AW-1:0]   tlo [9];
  logic signed [AW-1:0]   thi [9];
  logic                   f3_valid;
  logic signed [AW-1:0]   f3_dlo [3];
  logic signed [AW-1:0]   f3_dhi [3];
  logic signed [AW-1:0]   f3_tlo [9];
  logic signed [AW-1:0]   f3_thi [9];
  logic signed [FW-1:0]   f3_cof [9];

  logic                   f4_valid;
  logic signed [TW-1:0]   f4_dterm [3];
  logic signed [TW-1:0]   f4_tterm [9];
  logic signed [FW-1:0]   f4_cof [9];

  logic                   f5_valid;
  logic signed [DW-1:0]   f5_det;
  logic signed [DW-1:0]   f5_tr [3];
  logic signed [FW-1:0]   f5_cof [9];

  // Row sequencer.
  logic                              ser_valid;
  logic [amic_pkg::ROW_W-1:0]        ser_row;
  logic signed [FW-1:0]              ser_cof [9];
  logic signed [DW-1:0]              ser_tr [3];
  logic signed [DW-1:0]              ser_det;
  logic                              ser_zero;
  logic signed [FW-1:0]              sel_cof [3];
  logic signed [DW-1:0]              sel_tr;
  logic signed [NUM_W-1:0]           lane_num [4];
  amic_pkg::coef_t                   lane_q [4];
  amic_pkg::row_meta_t               meta [LAT];

  // Handshake and stall chain.
  assign adv          = !meta[LAT-1].valid || row_ready;
  assign ser_take     = adv && (!ser_valid || ser_row == amic_pkg::ROW_LAST);
  assign en5          = !f5_valid || ser_take;
  assign en4          = !f4_valid || en5;
  assign en3          = !f3_valid || en4;
  assign en2          = !f2_valid || en3;
  assign en1          = !f1_valid || en2;
  assign matrix_ready = en1;

  // Stage 1: element products for the nine cofactors.
  always_comb begin
    e[0]  = matrix.row1_col1;
    e[1]  = matrix.row1_col2;
    e[2]  = matrix.row1_col3;
    e[3]  = matrix.row1_shift;
    e[4]  = matrix.row2_col1;
    e[5]  = matrix.row2_col2;
    e[6]  = matrix.row2_col3;
    e[7]  = matrix.row2_shift;
    e[8]  = matrix.row3_col1;
    e[9]  = matrix.row3_col2;
    e[10] = matrix.row3_col3;
    e[11] = matrix.row3_shift;
    for (int i = 0; i < 9; i++) begin
      prod[2*i]   = PW'(e[amic_pkg::COF_A[i]]) * PW'(e[amic_pkg::COF_B[i]]);
      prod[2*i+1] = PW'(e[amic_pkg::COF_C[i]]) * PW'(e[amic_pkg::COF_D[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en1) begin
      f1_valid <= matrix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1_prod <= prod;
      f1_e[0] <= e[0];
      f1_e[1] <= e[1];
      f1_e[2] <= e[2];
      f1_t[0] <= e[3];
      f1_t[1] <= e[7];
      f1_t[2] <= e[11];
    end
  end

  // Stage 2: cofactors.
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en2) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 9; i++) begin
        f2_cof[i] <= FW'(f1_prod[2*i]) - FW'(f1_prod[2*i+1]);
      end
      f2_e <= f1_e;
      f2_t <= f1_t;
    end
  end

  // Stage 3: partial products, each cofactor cut into a low and a high slice.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlo[k] = AW'(f2_e[k]) * AW'($signed({1'b0, f2_cof[3*k][LW-1:0]}));
      dhi[k] = AW'(f2_e[k]) * AW'($signed(f2_cof[3*k][FW-1:LW]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tlo[3*r+k] = AW'(f2_t[k]) * AW'($signed({1'b0, f2_cof[3*r+k][LW-1:0]}));
        thi[3*r+k] = AW'(f2_t[k]) * AW'($signed(f2_cof[3*r+k][FW-1:LW]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (en3) begin
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      f3_dlo <= dlo;
      f3_dhi <= dhi;
      f3_tlo <= tlo;
      f3_thi <= thi;
      f3_cof <= f2_cof;
    end
  end

  // Stage 4: join slices into full products.
  always_ff @(posedge clk) begin
    if (rst) begin
      f4_valid <= 1'b0;
    end else if (en4) begin
      f4_valid <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < 3; k++) begin
        f4_dterm[k] <= (TW'(f3_dhi[k]) <<< LW) + TW'(f3_dlo[k]);
      end
      for (int i = 0; i < 9; i++) begin
        f4_tterm[i] <= (TW'(f3_thi[i]) <<< LW) + TW'(f3_tlo[i]);
      end
      f4_cof <= f3_cof;
    end
  end

  // Stage 5: determinant and negated translation numerators.
  always_ff @(posedge clk) begin
    if (rst) begin
      f5_valid <= 1'b0;
    end else if (en5) begin
      f5_valid <= f4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      f5_det <= DW'(f4_dterm[0]) + DW'(f4_dterm[1]) + DW'(f4_dterm[2]);
      for (int r = 0; r < 3; r++) begin
        f5_tr[r] <= DW'(0) - DW'(f4_tterm[3*r]) - DW'(f4_tterm[3*r+1])
                    - DW'(f4_tterm[3*r+2]);
      end
      f5_cof <= f4_cof;
    end
  end

  // Row sequencer: holds one matrix and issues its three rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_row   <= amic_pkg::ROW_FIRST;
    end else if (ser_take) begin
      ser_valid <= f5_valid;
      ser_row   <= amic_pkg::ROW_FIRST;
    end else if (adv && ser_valid) begin
      ser_row   <= ser_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_cof  <= f5_cof;
      ser_tr   <= f5_tr;
      ser_det  <= f5_det;
      ser_zero <= (f5_det == '0);
    end
  end

  // Pick the current row's cofactors and translation.
  always_comb begin
    unique case (ser_row)
      amic_pkg::ROW_FIRST: begin
        sel_cof[0] = ser_cof[0];
        sel_cof[1] = ser_cof[1];
        sel_cof[2] = ser_cof[2];
        sel_tr     = ser_tr[0];
      end
      amic_pkg::ROW_MID: begin
        sel_cof[0] = ser_cof[3];
        sel_cof[1] = ser_cof[4];
        sel_cof[2] = ser_cof[5];
        sel_tr     = ser_tr[1];
      end
      amic_pkg::ROW_LAST: begin
        sel_cof[0] = ser_cof[6];
        sel_cof[1] = ser_cof[7];
        sel_cof[2] = ser_cof[8];
        sel_tr     = ser_tr[2];
      end
      default: begin
        sel_cof[0] = '0;
        sel_cof[1] = '0;
        sel_cof[2] = '0;
        sel_tr     = '0;
      end
    endcase
  end

  // Scale numerators to the output fraction.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_num[k] = NUM_W'(sel_cof[k]) <<< (2 * FRAC_BITS);
    end
    lane_num[3] = NUM_W'(sel_tr) <<< FRAC_BITS;
  end

  // Four division lanes, one per output coefficient.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    amic_div #(
      .NUM_W(NUM_W),
      .DEN_W(DW)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (lane_num[k]),
      .den (ser_det),
      .quot(lane_q[k])
    );
  end

  // Row tags follow the lanes stage for stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        meta[i] <= '0;
      end
    end else if (adv) begin
      meta[0].valid      <= ser_valid;
      meta[0].row_number <= ser_row;
      meta[0].last_row   <= (ser_row == amic_pkg::ROW_LAST);
      meta[0].singular   <= ser_zero;
      for (int i = 1; i < LAT; i++) begin
        meta[i] <= meta[i-1];
      end
    end
  end

  // Result row; a singular matrix gives zero coefficients.
  assign row_valid      = meta[LAT-1].valid;
  assign row.out_col1   = meta[LAT-1].singular ? '0 : lane_q[0];
  assign row.out_col2   = meta[LAT-1].singular ? '0 : lane_q[1];
  assign row.out_col3   = meta[LAT-1].singular ? '0 : lane_q[2];
  assign row.out_shift  = meta[LAT-1].singular ? '0 : lane_q[3];
  assign row.row_number = meta[LAT-1].row_number;
  assign row.last_row   = meta[LAT-1].last_row;
  assign row.singular   = meta[LAT-1].singular;

  // Checks.
  `AMIC_ASSERT_NOW(a_last_tag, row_valid, row.last_row == (row.row_number == amic_pkg::ROW_LAST), "last_row disagrees with row_number")
  `AMIC_ASSERT_NEXT(a_seq_hold, ser_valid && !adv, ser_valid && $stable(ser_row), "row sequencer moved during a stall")
  `AMIC_ASSERT_NEXT(a_front_hold, f5_valid && !en5, f5_valid && $stable(f5_det), "matrix stage lost a matrix during a stall")

endmodule
